[src/lfs_pkg.sv]
// ----------------------------------------------------------------------------
// lfs_pkg: shared types and constants for the line follower steering block
// Holds the action codes, the register map, the reset values and the structs
// that carry the configuration, the steering state and a motor command.
// ----------------------------------------------------------------------------
`default_nettype none

package lfs_pkg;

  // Last steering action kept between samples.
  typedef enum logic [2:0] {
    ACT_NONE     = 3'd0,
    ACT_STRAIGHT = 3'd1,
    ACT_CURVE_R  = 3'd2,
    ACT_CURVE_L  = 3'd3,
    ACT_SPIN_L   = 3'd4,
    ACT_SPIN_R   = 3'd5
  } action_t;

  // Register map of the configuration channel.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_STRAIGHT_SPEED = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TURN_SPEED     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPIN_SPEED     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INNER_SPEED    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BOOST_STEP     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_BOOST_LIMIT    = 3'd5;

  localparam int unsigned SPEED_W = 8;
  localparam int unsigned BOOST_W = 7;
  localparam int unsigned HOLD_W  = 7;

  // Register reset values.
  localparam logic [SPEED_W-1:0] RST_STRAIGHT_SPEED = 8'd83;
  localparam logic [SPEED_W-1:0] RST_TURN_SPEED     = 8'd150;
  localparam logic [SPEED_W-1:0] RST_SPIN_SPEED     = 8'd170;
  localparam logic [SPEED_W-1:0] RST_INNER_SPEED    = 8'd55;
  localparam logic [BOOST_W-1:0] RST_BOOST_STEP     = 7'd7;
  localparam logic [BOOST_W-1:0] RST_BOOST_LIMIT    = 7'd100;

  // Fixed growth added on top of boost_step.
  localparam logic [BOOST_W-1:0] BOOST_BASE = 7'd3;

  // Hold times in milliseconds.
  localparam logic [HOLD_W-1:0] HOLD_NONE  = 7'd0;
  localparam logic [HOLD_W-1:0] HOLD_SHORT = 7'd10;
  localparam logic [HOLD_W-1:0] HOLD_SPIN  = 7'd90;
  localparam logic [HOLD_W-1:0] HOLD_LONG  = 7'd120;

  typedef struct packed {
    logic [SPEED_W-1:0] straight_speed;
    logic [SPEED_W-1:0] turn_speed;
    logic [SPEED_W-1:0] spin_speed;
    logic [SPEED_W-1:0] inner_speed;
    logic [BOOST_W-1:0] boost_step;
    logic [BOOST_W-1:0] boost_limit;
  } cfg_t;

  typedef struct packed {
    action_t            last_action;
    logic [BOOST_W-1:0] left_boost;
    logic [BOOST_W-1:0] right_boost;
  } steer_state_t;

  typedef struct packed {
    logic               changed;
    logic [SPEED_W-1:0] left_speed;
    logic               left_reverse;
    logic [SPEED_W-1:0] right_speed;
    logic               right_reverse;
    logic [HOLD_W-1:0]  hold_ms;
  } motor_cmd_t;

endpackage

`default_nettype wire

[src/line_follower_steering.sv]
// ----------------------------------------------------------------------------
// line_follower_steering: motor command decision for a five-sensor follower
// Turns each line-sensor sample into one motor command, keeping the last
// steering action and the two curve boosts between samples.
// ----------------------------------------------------------------------------
// The block takes one sensor sample per clock while the command output is not
// stalled and returns exactly one motor command for each: the sample is
// registered in the input register, decoded combinationally from it, and the
// command lands in an output register. The only loop is the last action and
// boost registers, which close around the decode so that every sample sees
// the state left by the one before it. A command waiting on a stalled output
// keeps any sample in the input register there, and no further sample enters
// until the output drains. Configuration writes are always accepted and should
// only be issued while no sample is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follower_steering (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Sample stream.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // [0] sense_one, [1] sense_two, [2] sense_mid, [3] sense_four,
  // [4] sense_five, [7:5] zero
  input  wire logic [7:0]                      s_tdata,
  // Command stream.
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // [0] changed, [8:1] left_speed, [9] left_reverse, [17:10] right_speed,
  // [18] right_reverse, [25:19] hold_ms, [31:26] zero
  output logic [31:0]                          m_tdata,
  // Register writes.
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lfs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lfs_pkg::SPEED_W-1:0]     cfg_data
);

  lfs_pkg::cfg_t          cfg;
  lfs_pkg::steer_state_t  state, state_next;
  lfs_pkg::motor_cmd_t    cmd_next, cmd;

  logic       in_valid;
  logic [4:0] sense;
  logic       advance;
  logic       fire;

  lfs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The output register can take a new command when empty or being drained.
  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  // The input register frees up whenever its sample moves on this cycle.
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      sense <= s_tdata[4:0];
    end
  end

  lfs_decide u_decide (
    .sense      (sense),
    .cfg        (cfg),
    .state      (state),
    .cmd        (cmd_next),
    .state_next (state_next)
  );

  // Steering state moves only when a sample is actually decoded.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.last_action <= lfs_pkg::ACT_NONE;
      state.left_boost  <= '0;
      state.right_boost <= '0;
    end else if (fire) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      cmd <= cmd_next;
    end
  end

  assign m_tdata = {6'd0, cmd.hold_ms, cmd.right_reverse, cmd.right_speed,
                    cmd.left_reverse, cmd.left_speed, cmd.changed};

`ifndef SYNTHESIS
  // A sample is refused only while one already sits in the input register.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid)
    else $error("sample refused with an empty input register");

  // A decoded sample always produces a command in the next cycle.
  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> m_tvalid)
    else $error("decoded sample produced no command");

  // A sample with all four outer sensors clear clears both boosts.
  a_clear_resets_boost: assert property (@(posedge clk) disable iff (rst)
    (fire && !sense[0] && !sense[1] && !sense[3] && !sense[4]) |=>
      (state.left_boost == '0 && state.right_boost == '0))
    else $error("boosts not cleared after an all-clear sample");

  // Hold time is always one of the four defined values.
  a_hold_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (cmd.hold_ms == lfs_pkg::HOLD_NONE || cmd.hold_ms == lfs_pkg::HOLD_SHORT ||
                  cmd.hold_ms == lfs_pkg::HOLD_SPIN || cmd.hold_ms == lfs_pkg::HOLD_LONG))
    else $error("illegal hold time on command");
`endif

endmodule

`default_nettype wire

[src/lfs_cfg.sv]
// ----------------------------------------------------------------------------
// lfs_cfg: configuration register file
// Six speed and boost registers, written one transaction at a time by index.
// ----------------------------------------------------------------------------
`default_nettype none

module lfs_cfg (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [lfs_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [lfs_pkg::SPEED_W-1:0]        cfg_data,
  output lfs_pkg::cfg_t                           cfg
);

  // Writes are always taken; indexes past the map are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.straight_speed <= lfs_pkg::RST_STRAIGHT_SPEED;
      cfg.turn_speed     <= lfs_pkg::RST_TURN_SPEED;
      cfg.spin_speed     <= lfs_pkg::RST_SPIN_SPEED;
      cfg.inner_speed    <= lfs_pkg::RST_INNER_SPEED;
      cfg.boost_step     <= lfs_pkg::RST_BOOST_STEP;
      cfg.boost_limit    <= lfs_pkg::RST_BOOST_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lfs_pkg::REG_STRAIGHT_SPEED: cfg.straight_speed <= cfg_data;
        lfs_pkg::REG_TURN_SPEED:     cfg.turn_speed     <= cfg_data;
        lfs_pkg::REG_SPIN_SPEED:     cfg.spin_speed     <= cfg_data;
        lfs_pkg::REG_INNER_SPEED:    cfg.inner_speed    <= cfg_data;
        lfs_pkg::REG_BOOST_STEP:     cfg.boost_step     <= cfg_data[lfs_pkg::BOOST_W-1:0];
        lfs_pkg::REG_BOOST_LIMIT:    cfg.boost_limit    <= cfg_data[lfs_pkg::BOOST_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/lfs_decide.sv]
// ----------------------------------------------------------------------------
// lfs_decide: steering decision logic
// Priority decode of one sensor sample against the kept state, giving the
// motor command and the next steering state.
// ----------------------------------------------------------------------------
`default_nettype none

module lfs_decide (
  input  wire logic [4:0]             sense,
  input  wire lfs_pkg::cfg_t          cfg,
  input  wire lfs_pkg::steer_state_t  state,
  output lfs_pkg::motor_cmd_t         cmd,
  output lfs_pkg::steer_state_t       state_next
);

  // Base speed plus boost, saturated at full duty.
  function automatic logic [lfs_pkg::SPEED_W-1:0] sat_add(
    input logic [lfs_pkg::SPEED_W-1:0] base,
    input logic [lfs_pkg::BOOST_W-1:0] boost
  );
    logic [lfs_pkg::SPEED_W:0] sum;
    sum = {1'b0, base} + {2'b00, boost};
    return sum[lfs_pkg::SPEED_W] ? {lfs_pkg::SPEED_W{1'b1}} : sum[lfs_pkg::SPEED_W-1:0];
  endfunction

  // Boost growth, saturated at the limit.
  function automatic logic [lfs_pkg::BOOST_W-1:0] grow(
    input logic [lfs_pkg::BOOST_W-1:0] boost,
    input logic [lfs_pkg::BOOST_W-1:0] step,
    input logic [lfs_pkg::BOOST_W-1:0] limit
  );
    logic [lfs_pkg::BOOST_W+1:0] sum;
    sum = {2'b00, boost} + {2'b00, lfs_pkg::BOOST_BASE} + {2'b00, step};
    return (sum > {2'b00, limit}) ? limit : sum[lfs_pkg::BOOST_W-1:0];
  endfunction

  function automatic lfs_pkg::motor_cmd_t drive(
    input logic [lfs_pkg::SPEED_W-1:0] l,
    input logic [lfs_pkg::SPEED_W-1:0] r,
    input logic [lfs_pkg::HOLD_W-1:0]  hold
  );
    lfs_pkg::motor_cmd_t c;
    c.changed       = 1'b1;
    c.left_speed    = l;
    c.left_reverse  = 1'b0;
    c.right_speed   = r;
    c.right_reverse = 1'b0;
    c.hold_ms       = hold;
    return c;
  endfunction

  logic s1, s2, s3, s4, s5;
  logic after_straight;
  logic [lfs_pkg::BOOST_W-1:0] lb, rb, lb_grow, rb_grow;
  logic [lfs_pkg::SPEED_W-1:0] turn_l, turn_r;
  lfs_pkg::motor_cmd_t spin_l90, spin_r90, spin_l120, spin_r120;
  lfs_pkg::motor_cmd_t curve_r0, curve_l0, replay;

  assign {s5, s4, s3, s2, s1} = sense;
  assign after_straight = (state.last_action == lfs_pkg::ACT_STRAIGHT);

  // A lowered limit takes effect on the stored boosts before anything else.
  assign lb = (state.left_boost  > cfg.boost_limit) ? cfg.boost_limit : state.left_boost;
  assign rb = (state.right_boost > cfg.boost_limit) ? cfg.boost_limit : state.right_boost;
  assign lb_grow = grow(lb, cfg.boost_step, cfg.boost_limit);
  assign rb_grow = grow(rb, cfg.boost_step, cfg.boost_limit);
  assign turn_l  = sat_add(cfg.turn_speed, lb);
  assign turn_r  = sat_add(cfg.turn_speed, rb);

  always_comb begin
    spin_l90  = drive(cfg.spin_speed, cfg.spin_speed, lfs_pkg::HOLD_SPIN);
    spin_l90.right_reverse = 1'b1;
    spin_r90  = drive(cfg.spin_speed, cfg.spin_speed, lfs_pkg::HOLD_SPIN);
    spin_r90.left_reverse  = 1'b1;
    spin_l120 = spin_l90;
    spin_l120.hold_ms = lfs_pkg::HOLD_LONG;
    spin_r120 = spin_r90;
    spin_r120.hold_ms = lfs_pkg::HOLD_LONG;
    curve_r0  = drive(turn_r, cfg.inner_speed, lfs_pkg::HOLD_NONE);
    curve_l0  = drive(cfg.inner_speed, turn_l, lfs_pkg::HOLD_NONE);
  end

  // Repeat of the last action, a stop after a straight; with no action yet the old command stays.
  always_comb begin
    unique case (state.last_action)
      lfs_pkg::ACT_SPIN_L:   replay = spin_l90;
      lfs_pkg::ACT_SPIN_R:   replay = spin_r90;
      lfs_pkg::ACT_CURVE_R:  replay = curve_r0;
      lfs_pkg::ACT_CURVE_L:  replay = curve_l0;
      lfs_pkg::ACT_STRAIGHT: replay = drive('0, '0, lfs_pkg::HOLD_NONE);
      default:               replay = '0;
    endcase
  end

  always_comb begin
    state_next.last_action = state.last_action;
    state_next.left_boost  = lb;
    state_next.right_boost = rb;
    priority if (!s1 && !s2 && !s4 && !s5) begin
      cmd = drive(cfg.straight_speed, cfg.straight_speed, lfs_pkg::HOLD_NONE);
      state_next.last_action = lfs_pkg::ACT_STRAIGHT;
      state_next.left_boost  = '0;
      state_next.right_boost = '0;
    end else if (s1 && s2 && s3 && s4) begin
      cmd = replay;
    end else if (s1 && s2 && s4 && s5) begin
      cmd = drive('0, '0, lfs_pkg::HOLD_NONE);
    end else if (s2 && s4) begin
      cmd = replay;
    end else if (s1 && s2) begin
      if (after_straight) begin
        cmd = spin_r120;
      end else begin
        cmd = curve_r0;
        state_next.right_boost = rb_grow;
      end
      state_next.last_action = lfs_pkg::ACT_SPIN_R;
    end else if (s4 && s5) begin
      if (after_straight) begin
        cmd = spin_l120;
        state_next.last_action = lfs_pkg::ACT_SPIN_L;
      end else begin
        cmd = curve_l0;
        state_next.left_boost  = lb_grow;
        state_next.last_action = lfs_pkg::ACT_CURVE_L;
      end
    end else if (s5) begin
      if (after_straight) begin
        // Spins left but records a right spin, as the original control does.
        cmd = spin_l90;
        state_next.last_action = lfs_pkg::ACT_SPIN_R;
      end else begin
        cmd = drive('0, turn_l, lfs_pkg::HOLD_NONE);
        state_next.left_boost  = lb_grow;
        state_next.last_action = lfs_pkg::ACT_CURVE_L;
      end
    end else if (s1) begin
      if (after_straight) begin
        cmd = spin_r90;
        state_next.last_action = lfs_pkg::ACT_SPIN_L;
      end else begin
        cmd = drive(turn_r, '0, lfs_pkg::HOLD_NONE);
        state_next.right_boost = rb_grow;
        state_next.last_action = lfs_pkg::ACT_CURVE_R;
      end
    end else if (s2) begin
      cmd = curve_r0;
      cmd.hold_ms = lfs_pkg::HOLD_SHORT;
      state_next.right_boost = rb_grow;
      state_next.last_action = lfs_pkg::ACT_CURVE_R;
    end else begin
      cmd = curve_l0;
      cmd.hold_ms = lfs_pkg::HOLD_SHORT;
      state_next.left_boost  = lb_grow;
      state_next.last_action = lfs_pkg::ACT_CURVE_L;
    end
  end

endmodule

`default_nettype wire
